### src/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Shared codes and types for the bounded stack with search.
// ----------------------------------------------------------------------------
package bss_pkg;

	localparam int CAP_W   = 11;
	localparam int DATA_W  = 64;
	localparam int FIDX_W  = 10;
	localparam int CNT_W   = 11;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	// register index (byte address / 4)
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic [2:0] CMD_PUSH   = 3'd0;
	localparam logic [2:0] CMD_POP    = 3'd1;
	localparam logic [2:0] CMD_PEEK   = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_SEARCH = 3'd4;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_EMPTY    = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	// controller status seen by the top level
	typedef struct packed {
		logic busy;  // item in flight over the memory
		logic load;  // result register written this cycle
	} bss_stat_t;

endpackage

### src/bounded_stack_with_search_core.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_search_core
// Bounded LIFO of 64-bit words with software-set capacity and linear search.
// ----------------------------------------------------------------------------
// The entries sit in one synchronous memory of DEPTH words (one write port,
// one registered read port); a sequencer takes one command at a time. Push,
// clear, refused commands and unknown codes produce their result the cycle
// after the transfer in. Pop and peek need one memory read, so their result
// passes through the S_READ state. Search reads one entry per cycle from the
// bottom up to the first match; the single read port sets that pace. While a
// pop, peek or search is in flight item_stall stays high, so one command per
// cycle is sustained only for commands that need no read, and only while
// res_stall is low. A finished result waits in the output register and does
// not block the next transfer in while res_stall is low. Capacity is written
// through the APB port at byte address 0; the user must do so only while the
// block is idle, which the block itself does not enforce. 0 acts as 1 and
// values above DEPTH act as DEPTH. Lowering it below the count drops nothing:
// the stack just reads as full. The memory needs no clearing pass after
// reset: only entries below the count are ever read. Search compares raw bit
// patterns; found_index and count are reported in 10 and 11 bits.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_core #(
	parameter int DEPTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// APB configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [bss_pkg::PADDR_W-1:0]        paddr,
	input  logic [bss_pkg::PDATA_W-1:0]        pwdata,
	output logic [bss_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready,
	// command channel
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [2:0]                         cmd,
	input  logic [bss_pkg::DATA_W-1:0]         value,
	// result channel
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic [1:0]                         status,
	output logic [bss_pkg::DATA_W-1:0]         data,
	output logic [bss_pkg::FIDX_W-1:0]         found_index,
	output logic [bss_pkg::CNT_W-1:0]          count,
	output logic                               empty_res,
	output logic                               full_res
);
	import bss_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CAP_W-1:0]  cap_q;
	logic              cfg_wr;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;
	bss_stat_t         stat;

	// config register: index is the word address
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr && paddr[2] == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

	bss_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.capacity    (cap_q),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.cmd         (cmd),
		.value       (value),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.status      (status),
		.data        (data),
		.found_index (found_index),
		.count       (count),
		.empty_res   (empty_res),
		.full_res    (full_res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.stat        (stat)
	);

	bss_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// every transfer in either yields a result next cycle or starts a walk
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> (res_valid || stat.busy))
		else $error("transfer in lost");

	// no new command while a memory walk is in flight
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> item_stall)
		else $error("command taken while busy");

	// a held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		stat.load |-> !(res_valid && res_stall))
		else $error("pending result overwritten");

	// capacity in effect is at least one, so never empty and full together
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(empty_res && full_res))
		else $error("empty and full both set");

endmodule

### src/bss_ram.sv
// ----------------------------------------------------------------------------
// bss_ram
// Single-port-write, single-port-read entry store, registered read data.
// ----------------------------------------------------------------------------
module bss_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [bss_pkg::DATA_W-1:0]   wdata,
	input  logic [AW-1:0]                raddr,
	output logic [bss_pkg::DATA_W-1:0]   rdata
);
	import bss_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### src/bss_ctrl.sv
// ----------------------------------------------------------------------------
// bss_ctrl
// Command sequencer: stack pointer, memory access, search walk and
// result register.
// ----------------------------------------------------------------------------
module bss_ctrl #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int CW    = 11
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [bss_pkg::CAP_W-1:0]    capacity,
	// command channel
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [2:0]                   cmd,
	input  logic [bss_pkg::DATA_W-1:0]   value,
	// result channel
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [1:0]                   status,
	output logic [bss_pkg::DATA_W-1:0]   data,
	output logic [bss_pkg::FIDX_W-1:0]   found_index,
	output logic [bss_pkg::CNT_W-1:0]    count,
	output logic                         empty_res,
	output logic                         full_res,
	// memory
	output logic                         mem_we,
	output logic [AW-1:0]                mem_waddr,
	output logic [bss_pkg::DATA_W-1:0]   mem_wdata,
	output logic [AW-1:0]                mem_raddr,
	input  logic [bss_pkg::DATA_W-1:0]   mem_rdata,
	output bss_pkg::bss_stat_t           stat
);
	import bss_pkg::*;

	localparam int WW = (CW > CAP_W) ? CW : CAP_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;

	logic [1:0]        state_q, state_nxt;
	logic [CW-1:0]     top_q, top_nxt;
	logic [AW-1:0]     idx_q, idx_nxt;
	logic [DATA_W-1:0] key_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] data_q;
	logic [FIDX_W-1:0] fidx_q;
	logic [CNT_W-1:0]  count_q;
	logic              empty_q, full_q;

	logic [WW-1:0]     cap_eff;
	logic              full_now;
	logic              accept;
	logic              load;
	logic [1:0]        r_status;
	logic [DATA_W-1:0] r_data;
	logic [AW-1:0]     r_idx;
	logic [CW-1:0]     top_dec;
	logic [CW-1:0]     idx_inc;

	// capacity in effect: zero acts as one, clipped to the built depth
	always_comb begin
		if (capacity == '0) begin
			cap_eff = WW'(1);
		end else if (WW'(capacity) > WW'(DEPTH)) begin
			cap_eff = WW'(DEPTH);
		end else begin
			cap_eff = WW'(capacity);
		end
	end

	assign full_now   = WW'(top_q) >= cap_eff;
	assign item_stall = (state_q != S_IDLE) || (out_valid_q && res_stall);
	assign accept     = item_valid && !item_stall;
	assign top_dec    = top_q - CW'(1);
	assign idx_inc    = CW'(idx_q) + CW'(1);

	always_comb begin
		state_nxt = state_q;
		top_nxt   = top_q;
		idx_nxt   = idx_q;
		load      = 1'b0;
		r_status  = STAT_OK;
		r_data    = '0;
		r_idx     = '0;
		mem_we    = 1'b0;
		mem_waddr = top_q[AW-1:0];
		mem_wdata = value;
		mem_raddr = top_dec[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_PUSH: begin
							load = 1'b1;
							if (full_now) begin
								r_status = STAT_FULL;
							end else begin
								mem_we  = 1'b1;
								top_nxt = top_q + CW'(1);
							end
						end
						CMD_POP, CMD_PEEK: begin
							if (top_q == '0) begin
								load     = 1'b1;
								r_status = STAT_EMPTY;
							end else begin
								state_nxt = S_READ;
								if (cmd == CMD_POP) begin
									top_nxt = top_dec;
								end
							end
						end
						CMD_CLEAR: begin
							load    = 1'b1;
							top_nxt = '0;
						end
						CMD_SEARCH: begin
							if (top_q == '0) begin
								load     = 1'b1;
								r_status = STAT_NOTFOUND;
							end else begin
								mem_raddr = '0;
								idx_nxt   = '0;
								state_nxt = S_SCAN;
							end
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				load      = 1'b1;
				r_data    = mem_rdata;
				state_nxt = S_IDLE;
			end
			S_SCAN: begin
				if (mem_rdata == key_q) begin
					load      = 1'b1;
					r_idx     = idx_q;
					state_nxt = S_IDLE;
				end else if (idx_inc == top_q) begin
					load      = 1'b1;
					r_status  = STAT_NOTFOUND;
					state_nxt = S_IDLE;
				end else begin
					idx_nxt   = idx_inc[AW-1:0];
					mem_raddr = idx_inc[AW-1:0];
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			top_q   <= top_nxt;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_nxt;
		if (accept) begin
			key_q <= value;
		end
		if (load) begin
			status_q <= r_status;
			data_q   <= r_data;
			fidx_q   <= FIDX_W'(r_idx);
			count_q  <= CNT_W'(top_nxt);
			empty_q  <= top_nxt == '0;
			full_q   <= WW'(top_nxt) >= cap_eff;
		end
	end

	assign res_valid   = out_valid_q;
	assign status      = status_q;
	assign data        = data_q;
	assign found_index = fidx_q;
	assign count       = count_q;
	assign empty_res   = empty_q;
	assign full_res    = full_q;

	assign stat.busy = state_q != S_IDLE;
	assign stat.load = load;

endmodule

### bench/stack_checker.sv
// ----------------------------------------------------------------------------
// stack_checker
// Watches the APB port and both channels of the bounded stack, predicts every
// result from its own copy of the stack and the capacity, and compares the
// transfers out field by field in arrival order.
// ----------------------------------------------------------------------------
module stack_checker #(
	parameter int DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [bss_pkg::PADDR_W-1:0] paddr,
	input  logic [bss_pkg::PDATA_W-1:0] pwdata,
	input  logic                        item_valid,
	input  logic                        item_stall,
	input  logic [2:0]                  cmd,
	input  logic [bss_pkg::DATA_W-1:0]  value,
	input  logic                        res_valid,
	input  logic                        res_stall,
	input  logic [1:0]                  status,
	input  logic [bss_pkg::DATA_W-1:0]  data,
	input  logic [bss_pkg::FIDX_W-1:0]  found_index,
	input  logic [bss_pkg::CNT_W-1:0]   count,
	input  logic                        empty_res,
	input  logic                        full_res,
	output int                          mismatches,
	output int                          owed
);
	import bss_pkg::*;

	localparam logic [PADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] data;
		logic [FIDX_W-1:0] found_index;
		logic [CNT_W-1:0]  count;
		logic              empty_flag;
		logic              full_flag;
	} stack_result_t;

	logic [DATA_W-1:0] stack_words [DEPTH];
	int unsigned       stack_height;
	logic [CAP_W-1:0]  capacity_reg;
	stack_result_t     stack_results_due[$];
	stack_result_t     seen;
	stack_result_t     want;

	initial mismatches = 0;

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] exp_val);
		if (mismatches < 100)
			$display("MISMATCH @%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
		mismatches++;
	endtask

	// applies one command to the shadow stack and returns the result it owes
	function automatic stack_result_t apply_stack_cmd(input logic [2:0] op,
			input logic [DATA_W-1:0] word);
		stack_result_t r;
		int unsigned   lim;
		int unsigned   k;
		r = '0;
		r.status = STAT_OK;
		// 0 behaves as 1, anything above the built depth as the depth
		lim = (capacity_reg == '0) ? 1 : ((capacity_reg > DEPTH) ? DEPTH : capacity_reg);
		case (op)
			CMD_PUSH: begin
				if (stack_height >= lim) begin
					r.status = STAT_FULL;
				end else begin
					stack_words[stack_height] = word;
					stack_height++;
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (stack_height == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.data = stack_words[stack_height-1];
					if (op == CMD_POP)
						stack_height--;
				end
			end
			CMD_CLEAR: stack_height = 0;
			CMD_SEARCH: begin
				r.status = STAT_NOTFOUND;
				for (k = 0; k < stack_height; k++) begin
					if (stack_words[k] === word) begin
						r.status = STAT_OK;
						r.found_index = FIDX_W'(k);
						break;
					end
				end
			end
			default: ;
		endcase
		r.count = CNT_W'(stack_height);
		r.empty_flag = (stack_height == 0);
		r.full_flag = (stack_height >= lim);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_height = 0;
			capacity_reg = CAP_RESET;
			stack_results_due.delete();
		end else begin
			if (res_valid && !res_stall) begin
				seen = '{status, data, found_index, count, empty_res, full_res};
				if (stack_results_due.size() == 0) begin
					report_mismatch("result transfer with none outstanding", DATA_W'(status), '0);
				end else begin
					want = stack_results_due.pop_front();
					if (seen.status !== want.status)
						report_mismatch("status", DATA_W'(seen.status), DATA_W'(want.status));
					if (seen.data !== want.data)
						report_mismatch("data", seen.data, want.data);
					if (seen.found_index !== want.found_index)
						report_mismatch("found_index", DATA_W'(seen.found_index),
							DATA_W'(want.found_index));
					if (seen.count !== want.count)
						report_mismatch("count", DATA_W'(seen.count), DATA_W'(want.count));
					if (seen.empty_flag !== want.empty_flag)
						report_mismatch("empty_res", DATA_W'(seen.empty_flag),
							DATA_W'(want.empty_flag));
					if (seen.full_flag !== want.full_flag)
						report_mismatch("full_res", DATA_W'(seen.full_flag),
							DATA_W'(want.full_flag));
				end
			end
			if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
				capacity_reg = pwdata[CAP_W-1:0];
			if (item_valid && !item_stall)
				stack_results_due.push_back(apply_stack_cmd(cmd, value));
		end
		owed = stack_results_due.size();
	end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the bounded stack with search: a directed opening over the
// empty, full and reserved-code corners and capacity edge cases, then random
// command bursts at a range of capacities, including one fill to the full
// built depth with deep searches. Checking lives in stack_checker.
// ----------------------------------------------------------------------------
module tb;
	import bss_pkg::*;

	localparam int DEPTH        = 1024;
	localparam int LIMIT_CYCLES = 8_000_000; // a full-depth search per item, several times over
	localparam int HOLD_CYCLES  = 300;       // long receiver hold-off
	localparam int TAIL_CYCLES  = 20;

	localparam logic [PADDR_W-1:0] CAP_ADDR       = {REG_CAPACITY, 2'b00};
	// codes above search are reserved and must behave as no-ops
	localparam logic [2:0]         CMD_RSVD_FIRST = CMD_SEARCH + 3'd1;
	localparam logic [2:0]         CMD_RSVD_LAST  = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	logic [2:0]           cmd = CMD_PUSH;
	logic [DATA_W-1:0]    value = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic [1:0]           status;
	logic [DATA_W-1:0]    data;
	logic [FIDX_W-1:0]    found_index;
	logic [CNT_W-1:0]     count;
	logic                 empty_res;
	logic                 full_res;

	int                   mismatches;
	int                   owed;
	int                   cycle_count = 0;
	bit                   idle_on = 1'b1;   // random gaps on both sides
	bit                   hold_req = 1'b0;  // ask the receiver for one long hold-off
	bit                   hold_done = 1'b0;
	int                   hold_cnt = 0;
	logic [DATA_W-1:0]    word_pool [8];    // small pool so searches hit often
	logic [31:0]          fill_tag;
	int                   k;

	bounded_stack_with_search_core #(.DEPTH(DEPTH)) u_top (.*);

	stack_checker #(.DEPTH(DEPTH)) u_chk (.*);

	always #5 clk = ~clk;

	// Run limit: only reached if the block hangs.
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side. Random stalls, except for one long hold-off once asked for;
	// the hold is counted here so the sender keeps offering transfers meanwhile
	// and the block backs up onto its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			res_stall <= 1'b1;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
		end else begin
			res_stall <= idle_on && ($urandom_range(0, 99) < 14);
		end
	end

	// One command transfer. Valid stays high on return so back-to-back
	// transfers need no second assignment in the same step.
	task automatic issue_cmd(input logic [2:0] op, input logic [DATA_W-1:0] word);
		while (idle_on && $urandom_range(0, 99) < 14) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		cmd <= op;
		value <= word;
		do @(posedge clk); while (item_stall);
	endtask

	// Sender must already have dropped valid.
	task automatic wait_results_settled();
		@(posedge clk);
		while (owed != 0) @(posedge clk);
	endtask

	// Capacity is only written with nothing in flight: every command owes
	// exactly one result, so an empty expectation list means the block is idle.
	task automatic program_capacity(input logic [CAP_W-1:0] cap);
		item_valid <= 1'b0;
		wait_results_settled();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= CAP_ADDR;
		pwdata <= PDATA_W'(cap);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Random commands; push_pct steers the fill level, the rest is split
	// between pop, peek, search, clear and the reserved codes.
	task automatic random_burst(input int n_items, input int push_pct);
		int                i;
		int                r;
		int                share;
		logic [2:0]        op;
		logic [DATA_W-1:0] word;
		for (i = 0; i < 8; i++)
			word_pool[i] = {$urandom, $urandom};
		for (i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 4) == 0)
				word = {$urandom, $urandom};
			else
				word = word_pool[$urandom_range(0, 7)];
			if (r < push_pct) begin
				op = CMD_PUSH;
			end else begin
				share = (r - push_pct) * 100 / (100 - push_pct);
				if (share < 30)
					op = CMD_POP;
				else if (share < 45)
					op = CMD_PEEK;
				else if (share < 90)
					op = CMD_SEARCH;
				else if (share < 95)
					op = CMD_CLEAR;
				else
					op = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
			end
			issue_cmd(op, word);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: empty store at reset capacity ---
		issue_cmd(CMD_POP, '1);
		issue_cmd(CMD_PEEK, '0);
		issue_cmd(CMD_SEARCH, '0);            // nothing to search
		issue_cmd(CMD_RSVD_FIRST, '1);
		issue_cmd(CMD_RSVD_LAST, '0);
		issue_cmd(CMD_CLEAR, '1);
		// extreme words; plus and minus zero differ as bit patterns
		issue_cmd(CMD_PUSH, '0);
		issue_cmd(CMD_PUSH, '1);
		issue_cmd(CMD_PUSH, 64'h8000_0000_0000_0000);
		issue_cmd(CMD_PUSH, '0);
		issue_cmd(CMD_SEARCH, '0);            // duplicate: lowest index wins
		issue_cmd(CMD_SEARCH, '1);
		issue_cmd(CMD_SEARCH, 64'h7FF8_0000_0000_0000);
		issue_cmd(CMD_PEEK, '1);
		issue_cmd(CMD_POP, '0);
		issue_cmd(CMD_RSVD_FIRST + 3'd1, '1); // reserved code with entries held
		issue_cmd(CMD_SEARCH, 64'h8000_0000_0000_0000);

		// capacity lowered below the count: reads full, nothing dropped
		program_capacity(11'd2);
		issue_cmd(CMD_PUSH, 64'h0123_4567_89AB_CDEF);
		issue_cmd(CMD_POP, '0);
		issue_cmd(CMD_PUSH, 64'hFEDC_BA98_7654_3210);
		issue_cmd(CMD_POP, '0);
		issue_cmd(CMD_PUSH, 64'h5555_AAAA_5555_AAAA);

		// zero capacity acts as one
		program_capacity(11'd0);
		issue_cmd(CMD_PUSH, '1);
		issue_cmd(CMD_CLEAR, '0);
		issue_cmd(CMD_PUSH, 64'hAAAA_5555_AAAA_5555);
		issue_cmd(CMD_PUSH, '0);

		// --- random bursts at several capacities ---
		program_capacity(11'd4);
		random_burst(120, 45);
		program_capacity(11'd0);
		random_burst(60, 45);

		// a long stretch with no gaps on either side
		idle_on <= 1'b0;
		program_capacity(11'd16);
		random_burst(180, 40);
		idle_on <= 1'b1;

		// receiver holds off for a long while as this burst starts
		program_capacity(11'd64);
		hold_req <= 1'b1;
		random_burst(200, 50);

		// fill to the built depth (capacity above depth is clamped), then
		// search deep; each word carries its own index in the low bits
		program_capacity(11'd2047);
		issue_cmd(CMD_CLEAR, {$urandom, $urandom});
		fill_tag = $urandom;
		for (k = 0; k < DEPTH + 6; k++)
			issue_cmd(CMD_PUSH, {fill_tag, 22'd0, 10'(k)});
		issue_cmd(CMD_SEARCH, {fill_tag, 22'd0, 10'd0});
		issue_cmd(CMD_SEARCH, {fill_tag, 22'd0, 10'd1023});
		issue_cmd(CMD_SEARCH, {fill_tag, 22'd0, 10'd511});
		for (k = 0; k < 4; k++)
			issue_cmd(CMD_SEARCH, {fill_tag, 22'd0, 10'($urandom_range(0, DEPTH - 1))});
		issue_cmd(CMD_SEARCH, {fill_tag, 22'd1, 10'd5}); // full walk, no match
		issue_cmd(CMD_PEEK, '0);
		issue_cmd(CMD_POP, '0);
		issue_cmd(CMD_SEARCH, {fill_tag, 22'd0, 10'd1023}); // just popped
		issue_cmd(CMD_PUSH, {$urandom, $urandom});
		issue_cmd(CMD_PUSH, {$urandom, $urandom});

		// full store at the exact reset capacity
		program_capacity(11'd1024);
		random_burst(60, 40);

		program_capacity(11'd37);
		issue_cmd(CMD_CLEAR, '0);
		random_burst(150, 35);

		program_capacity(11'($urandom_range(2, 48)));
		random_burst(120, 45);

		// drain, then let the pipeline settle
		item_valid <= 1'b0;
		wait_results_settled();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
